@@ sv/nearest_track_segment_search_unit_defines.svh @@
// Assertion macros for the nearest track segment search unit.
// Expects clk and rst_n in the scope of each use.
`ifndef NEAREST_TRACK_SEGMENT_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_TRACK_SEGMENT_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication.
`define NTSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NTSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ntss_pkg.sv @@
// Package of the nearest track segment search unit: widths, codes, types.
// No dependencies.
package ntss_pkg;

  localparam int LAT_W     = 30;
  localparam int LON_W     = 31;
  localparam int ALT_W     = 24;
  localparam int DIST_W    = 26;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] LIMIT_RESET  = DIST_W'(419430);
  localparam logic [63:0]       SQRT_BIT0    = 64'h4000_0000_0000_0000;
  localparam logic [63:0]       ROUND_HALF   = 64'h0000_0000_8000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIFF, ST_DOT0, ST_DOT1, ST_LEN0, ST_LEN1, ST_LWAIT, ST_DEC,
    ST_DIV, ST_OFFX, ST_OFFY, ST_SQX, ST_SQY, ST_SWAIT, ST_SINIT, ST_SQRT, ST_FIN
  } ntss_state_t;

  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } iter_mode_t;

  typedef struct packed {
    logic        en;
    logic        clr;
    logic        neg;
    logic [31:0] a;
    logic [31:0] b;
  } mac_req_t;

  typedef struct packed {
    logic        start;
    iter_mode_t  mode;
    logic [63:0] a;
    logic [63:0] b;
  } iter_req_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

@@ sv/ntss_in_if.sv @@
// Track point channel: valid, ready and one point.
// Depends on ntss_pkg.
interface ntss_in_if import ntss_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] point_latitude;
  logic signed [LON_W-1:0] point_longitude;
  logic [ALT_W-1:0]        point_altitude;
  logic                    last_point;

  modport source (output valid, point_latitude, point_longitude, point_altitude,
                  last_point, input ready);
  modport sink   (input valid, point_latitude, point_longitude, point_altitude,
                  last_point, output ready);
endinterface

@@ sv/ntss_out_if.sv @@
// Result channel: valid, ready and one search result.
// Depends on ntss_pkg.
interface ntss_out_if import ntss_pkg::*;;
  logic              valid;
  logic              ready;
  logic              found;
  logic [DIST_W-1:0] nearest_distance;
  logic [ALT_W-1:0]  nearest_altitude;

  modport source (output valid, found, nearest_distance, nearest_altitude, input ready);
  modport sink   (input valid, found, nearest_distance, nearest_altitude, output ready);
endinterface

@@ sv/ntss_mac.sv @@
// Shared 32x32 multiplier with registered product and signed 64-bit accumulator.
// Depends on ntss_pkg.
module ntss_mac import ntss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  mac_req_t           req,
  output logic [63:0]        prod,
  output logic signed [63:0] acc
);

  logic [63:0]        prod_r;
  logic               neg_r;
  logic               clr_r;
  logic               pend_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] term;

  always_comb begin
    term = neg_r ? -signed'(prod_r) : signed'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= req.en;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= req.a * req.b;
      neg_r  <= req.neg;
      clr_r  <= req.clr;
    end
    if (pend_r) begin
      acc_r <= (clr_r ? 64'sd0 : acc_r) + term;
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

@@ sv/ntss_iter.sv @@
// Shared shift-subtract unit: 32-step fraction divide or 64-bit integer square root.
// Depends on ntss_pkg.
module ntss_iter import ntss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  iter_req_t   req,
  output logic        done,
  output logic [31:0] quo,
  output logic [32:0] root
);

  logic [63:0] a_r, b_r, q_r;
  iter_mode_t  mode_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic [63:0] lhs, rhs, dif;
  logic        ge;

  always_comb begin
    lhs = (mode_r == MODE_DIV) ? {a_r[62:0], 1'b0} : a_r;
    rhs = (mode_r == MODE_DIV) ? b_r : b_r + q_r;
    ge  = lhs >= rhs;
    dif = lhs - rhs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r    <= req.a;
      b_r    <= req.b;
      q_r    <= (req.mode == MODE_DIV) ? 64'd0 : SQRT_BIT0;
      mode_r <= req.mode;
    end else if (run_r) begin
      a_r <= ge ? dif : lhs;
      if (mode_r == MODE_DIV) begin
        q_r <= {q_r[62:0], ge};
      end else begin
        b_r <= ge ? ({1'b0, b_r[63:1]} + q_r) : {1'b0, b_r[63:1]};
        q_r <= {2'b00, q_r[63:2]};
      end
    end
  end

  assign done = run_r && (cnt_r == 5'd31);
  assign quo  = q_r[31:0];
  assign root = b_r[32:0];

endmodule

@@ sv/nearest_track_segment_search_unit.sv @@
// A first point of a track goes from ST_IDLE to ST_FIN; a segment whose nearest point is
// an end point skips ST_DIV, ST_OFFX and ST_OFFY, which an interior nearest point adds.
// The result of a last point is valid on the cycle after that point finishes.
// Throughput: one point at a time; the 32-step divider and 32-step square root in
// ntss_iter and the six to eight products through ntss_mac set the figure.
// Reset (synchronous, rst_n low): track state cleared, configuration registers to reset values.
module nearest_track_segment_search_unit import ntss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  ntss_in_if.sink              in_ch,
  ntss_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

`include "nearest_track_segment_search_unit_defines.svh"

  ntss_state_t state_r, state_nxt;

  logic signed [LAT_W-1:0] qlat_r;
  logic signed [LON_W-1:0] qlon_r;
  logic [DIST_W-1:0]       limit_r;

  logic signed [LAT_W-1:0] prev_lat_r;
  logic signed [LON_W-1:0] prev_lon_r;
  logic                    have_prev_r;
  logic [DIST_W-1:0]       best_dist_r, best_dist_nxt;
  logic [ALT_W-1:0]        best_alt_r, best_alt_nxt;
  logic                    best_found_r, best_found_nxt;

  logic signed [LAT_W-1:0] pt_lat_r;
  logic signed [LON_W-1:0] pt_lon_r;
  logic [ALT_W-1:0]        pt_alt_r;
  logic                    last_r;

  logic signed [31:0] dx_r, dy_r, wx_r, wy_r, ex_r, ey_r;
  logic signed [63:0] dot_r;
  logic               interior_r;

  logic               out_valid_r;
  logic               out_found_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic [ALT_W-1:0]   out_alt_r;

  mac_req_t           mac_req;
  logic [63:0]        mac_prod;
  logic signed [63:0] mac_acc;
  iter_req_t          iter_req;
  logic               it_done;
  logic [31:0]        it_quo;
  logic [32:0]        it_root;

  logic               in_xfer, fin_go, interior, upd;
  logic [31:0]        off;
  logic [63:0]        rnd;
  logic [DIST_W-1:0]  seg_dist;

  ntss_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .prod  (mac_prod),
    .acc   (mac_acc)
  );

  ntss_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iter_req),
    .done  (it_done),
    .quo   (it_quo),
    .root  (it_root)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign fin_go      = !last_r || !out_valid_r || out_ch.ready;
  assign interior    = (mac_acc != 64'sd0) && (dot_r > 64'sd0) && (dot_r < mac_acc);

  always_comb begin
    rnd  = mac_prod + ROUND_HALF;
    off  = rnd[63:32];
    seg_dist = (it_root[32:DIST_W] != '0) ? DIST_MAX : it_root[DIST_W-1:0];
    upd  = have_prev_r && (seg_dist < limit_r) && (seg_dist < best_dist_r);
    best_dist_nxt  = upd ? seg_dist : best_dist_r;
    best_alt_nxt   = upd ? pt_alt_r : best_alt_r;
    best_found_nxt = upd || best_found_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = have_prev_r ? ST_DIFF : ST_FIN;
      ST_DIFF:  state_nxt = ST_DOT0;
      ST_DOT0:  state_nxt = ST_DOT1;
      ST_DOT1:  state_nxt = ST_LEN0;
      ST_LEN0:  state_nxt = ST_LEN1;
      ST_LEN1:  state_nxt = ST_LWAIT;
      ST_LWAIT: state_nxt = ST_DEC;
      ST_DEC:   state_nxt = interior ? ST_DIV : ST_SQX;
      ST_DIV:   if (it_done) state_nxt = ST_OFFX;
      ST_OFFX:  state_nxt = ST_OFFY;
      ST_OFFY:  state_nxt = ST_SQX;
      ST_SQX:   state_nxt = ST_SQY;
      ST_SQY:   state_nxt = ST_SWAIT;
      ST_SWAIT: state_nxt = ST_SINIT;
      ST_SINIT: state_nxt = ST_SQRT;
      ST_SQRT:  if (it_done) state_nxt = ST_FIN;
      ST_FIN:   if (fin_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mac_req  = '0;
    iter_req = '0;
    unique case (state_r)
      ST_DOT0: begin
        mac_req = '{en: 1'b1, clr: 1'b1, neg: wx_r[31] ^ dx_r[31],
                    a: mag32(wx_r), b: mag32(dx_r)};
      end
      ST_DOT1: begin
        mac_req = '{en: 1'b1, clr: 1'b0, neg: wy_r[31] ^ dy_r[31],
                    a: mag32(wy_r), b: mag32(dy_r)};
      end
      ST_LEN0: mac_req = '{en: 1'b1, clr: 1'b1, neg: 1'b0, a: mag32(dx_r), b: mag32(dx_r)};
      ST_LEN1: mac_req = '{en: 1'b1, clr: 1'b0, neg: 1'b0, a: mag32(dy_r), b: mag32(dy_r)};
      ST_DEC: begin
        iter_req = '{start: interior, mode: MODE_DIV, a: unsigned'(dot_r),
                     b: unsigned'(mac_acc)};
      end
      ST_OFFX: mac_req = '{en: 1'b1, clr: 1'b1, neg: 1'b0, a: it_quo, b: mag32(dx_r)};
      ST_OFFY: mac_req = '{en: 1'b1, clr: 1'b1, neg: 1'b0, a: it_quo, b: mag32(dy_r)};
      ST_SQX:  mac_req = '{en: 1'b1, clr: 1'b1, neg: 1'b0, a: mag32(ex_r), b: mag32(ex_r)};
      ST_SQY:  mac_req = '{en: 1'b1, clr: 1'b0, neg: 1'b0, a: mag32(ey_r), b: mag32(ey_r)};
      ST_SINIT: begin
        iter_req = '{start: 1'b1, mode: MODE_SQRT, a: unsigned'(mac_acc), b: 64'd0};
      end
      default: begin
        mac_req  = '0;
        iter_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      qlat_r       <= '0;
      qlon_r       <= '0;
      limit_r      <= LIMIT_RESET;
      prev_lat_r   <= '0;
      prev_lon_r   <= '0;
      have_prev_r  <= 1'b0;
      best_dist_r  <= DIST_MAX;
      best_alt_r   <= '0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_QUERY_LAT: qlat_r  <= cfg_data[LAT_W-1:0];
          CFG_QUERY_LON: qlon_r  <= cfg_data[LON_W-1:0];
          CFG_LIMIT:     limit_r <= cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_FIN && fin_go && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_FIN && fin_go) begin
        if (last_r) begin
          prev_lat_r   <= '0;
          prev_lon_r   <= '0;
          have_prev_r  <= 1'b0;
          best_dist_r  <= DIST_MAX;
          best_alt_r   <= '0;
          best_found_r <= 1'b0;
        end else begin
          prev_lat_r   <= pt_lat_r;
          prev_lon_r   <= pt_lon_r;
          have_prev_r  <= 1'b1;
          best_dist_r  <= best_dist_nxt;
          best_alt_r   <= best_alt_nxt;
          best_found_r <= best_found_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pt_lat_r <= in_ch.point_latitude;
      pt_lon_r <= in_ch.point_longitude;
      pt_alt_r <= in_ch.point_altitude;
      last_r   <= in_ch.last_point;
    end
    unique case (state_r)
      ST_DIFF: begin
        dx_r <= 32'(pt_lat_r) - 32'(prev_lat_r);
        dy_r <= 32'(pt_lon_r) - 32'(prev_lon_r);
        wx_r <= 32'(qlat_r) - 32'(prev_lat_r);
        wy_r <= 32'(qlon_r) - 32'(prev_lon_r);
      end
      ST_LEN1: dot_r <= mac_acc;
      ST_DEC: begin
        interior_r <= interior;
        if (mac_acc == 64'sd0 || dot_r <= 64'sd0) begin
          ex_r <= wx_r;
          ey_r <= wy_r;
        end else begin
          ex_r <= wx_r - dx_r;
          ey_r <= wy_r - dy_r;
        end
      end
      ST_OFFY: ex_r <= wx_r - (dx_r[31] ? -signed'(off) : signed'(off));
      ST_SQX: begin
        if (interior_r) begin
          ey_r <= wy_r - (dy_r[31] ? -signed'(off) : signed'(off));
        end
      end
      ST_FIN: begin
        if (fin_go && last_r) begin
          out_found_r <= best_found_nxt;
          out_dist_r  <= best_found_nxt ? best_dist_nxt : '0;
          out_alt_r   <= best_found_nxt ? best_alt_nxt : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.found            = out_found_r;
  assign out_ch.nearest_distance = out_dist_r;
  assign out_ch.nearest_altitude = out_alt_r;

  `NTSS_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !in_ch.ready, "ready right after transfer")
  `NTSS_ASSERT_SAME(a_best_idle, !best_found_r, best_dist_r == DIST_MAX, "best set without find")
  `NTSS_ASSERT_SAME(a_iter_owner, it_done, state_r == ST_DIV || state_r == ST_SQRT, "stray done")
  `NTSS_ASSERT_SAME(a_out_from_fin, $rose(out_valid_r), $past(state_r) == ST_FIN, "stray result")

endmodule

@@ tb/nearest_track_segment_search_unit_test.sv @@
// Testbench of nearest_track_segment_search_unit: drives tracks of points over random
// configurations and checks each search result against a built-in predictor.
// Depends on ntss_pkg, ntss_in_if, ntss_out_if and the unit itself.
module nearest_track_segment_search_unit_test import ntss_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam longint LAT_LO = -377487360;
  localparam longint LAT_HI = 377487360;
  localparam longint LON_LO = -754974720;
  localparam longint LON_HI = 754974720;
  localparam int     IDLE_LIMIT = 20000;
  localparam int     TAIL_CYCLES = 200;
  localparam int     ITEM_TARGET = 1850;

  typedef struct {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic [ALT_W-1:0]        alt;
    logic                    last;
  } point_t;

  typedef struct {
    logic              found;
    logic [DIST_W-1:0] near_dist;
    logic [ALT_W-1:0]  alt;
  } search_result_t;

  class track_scoreboard;
    logic signed [LAT_W-1:0] q_lat;
    logic signed [LON_W-1:0] q_lon;
    logic [DIST_W-1:0]       limit;
    longint                  prev_lat;
    longint                  prev_lon;
    bit                      have_prev;
    logic [DIST_W-1:0]       best_dist;
    logic [ALT_W-1:0]        best_alt;
    bit                      best_found;
    search_result_t          pending[$];
    int                      errors;

    function new();
      q_lat = '0;
      q_lon = '0;
      limit = LIMIT_RESET;
      errors = 0;
      clear_track();
    endfunction

    function void clear_track();
      prev_lat = 0;
      prev_lon = 0;
      have_prev = 0;
      best_dist = DIST_MAX;
      best_alt = '0;
      best_found = 0;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_QUERY_LAT: q_lat = data[LAT_W-1:0];
        CFG_QUERY_LON: q_lon = data[LON_W-1:0];
        CFG_LIMIT:     limit = data[DIST_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint offset_along(longint unsigned lam, longint d);
      longint unsigned p;
      p = (lam * magnitude(d) + 64'h8000_0000) >> 32;
      return (d < 0) ? -longint'(p) : longint'(p);
    endfunction

    function logic [DIST_W-1:0] segment_distance(longint ax, longint ay, longint bx,
                                                 longint by);
      longint px, py, dx, dy, wx, wy, dot, len, ex, ey;
      longint unsigned rem, lam, sq, r;
      px = q_lat;
      py = q_lon;
      dx = bx - ax;
      dy = by - ay;
      wx = px - ax;
      wy = py - ay;
      dot = wx * dx + wy * dy;
      len = dx * dx + dy * dy;
      if (len == 0 || dot <= 0) begin
        ex = wx;
        ey = wy;
      end else if (dot >= len) begin
        ex = px - bx;
        ey = py - by;
      end else begin
        rem = dot;
        lam = 0;
        for (int i = 0; i < 32; i++) begin
          rem <<= 1;
          lam <<= 1;
          if (rem >= longint'(len)) begin
            rem -= len;
            lam |= 1;
          end
        end
        ex = wx - offset_along(lam, dx);
        ey = wy - offset_along(lam, dy);
      end
      sq = magnitude(ex) * magnitude(ex) + magnitude(ey) * magnitude(ey);
      r = root_floor(sq);
      return (r > DIST_MAX) ? DIST_MAX : r[DIST_W-1:0];
    endfunction

    function void note_point(point_t p);
      logic [DIST_W-1:0] d;
      search_result_t res;
      if (have_prev) begin
        d = segment_distance(prev_lat, prev_lon, p.lat, p.lon);
        if (d < limit && d < best_dist) begin
          best_dist = d;
          best_alt = p.alt;
          best_found = 1;
        end
      end
      prev_lat = p.lat;
      prev_lon = p.lon;
      have_prev = 1;
      if (p.last) begin
        res.found = best_found;
        res.near_dist = best_found ? best_dist : '0;
        res.alt = best_found ? best_alt : '0;
        pending.insert(pending.size(), res);
        clear_track();
      end
    endfunction

    function void check(logic found, logic [DIST_W-1:0] near_dist, logic [ALT_W-1:0] alt);
      search_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: found=%0d distance=%0d altitude=%0d", found, near_dist,
               alt);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (found !== e.found) begin
        $error("found: expected %0d, actual %0d", e.found, found);
        errors++;
      end
      if (near_dist !== e.near_dist) begin
        $error("nearest_distance: expected %0d, actual %0d", e.near_dist, near_dist);
        errors++;
      end
      if (alt !== e.alt) begin
        $error("nearest_altitude: expected %0d, actual %0d", e.alt, alt);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ntss_in_if  in_ch();
  ntss_out_if out_ch();

  nearest_track_segment_search_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  track_scoreboard sb = new();
  bit quiet_phase;
  bit hold_armed;
  int results_seen;
  int idle_cycles;
  int items_sent;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.point_latitude = '0;
    in_ch.point_longitude = '0;
    in_ch.point_altitude = '0;
    in_ch.last_point = 0;
    out_ch.ready = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check(out_ch.found, out_ch.nearest_distance, out_ch.nearest_altitude);
      results_seen++;
    end
    if (rst_n && ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold while the sender keeps offering.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = quiet_phase ? 0 : $urandom_range(0, 17);
      if (hold_armed && results_seen >= 4) begin
        hold_armed = 0;
        gap = 3000;
      end
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.configure(idx, data);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_point(point_t p);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.point_latitude <= p.lat;
    in_ch.point_longitude <= p.lon;
    in_ch.point_altitude <= p.alt;
    in_ch.last_point <= p.last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_point(p);
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic point_t make_point(longint lat, longint lon, int alt, bit last);
    point_t p;
    p.lat = LAT_W'(lat);
    p.lon = LON_W'(lon);
    p.alt = ALT_W'(alt);
    p.last = last;
    return p;
  endfunction

  function automatic point_t random_point(bit last);
    longint span, lat, lon;
    span = longint'(sb.limit) * 2 + 2000;
    if ($urandom_range(0, 4) == 0) begin
      lat = longint'($urandom_range(0, 755000000)) - 377500000;
      lon = longint'($urandom_range(0, 1510000000)) - 755000000;
    end else begin
      lat = longint'(sb.q_lat) + longint'($urandom_range(0, 32'(2 * span))) - span;
      lon = longint'(sb.q_lon) + longint'($urandom_range(0, 32'(2 * span))) - span;
    end
    return make_point(clamp(lat, LAT_LO, LAT_HI), clamp(lon, LON_LO, LON_HI),
                      $urandom_range(0, 24'hFFFFFF), last);
  endfunction

  function automatic logic [CFG_W-1:0] rand_lat();
    return CFG_W'(clamp(longint'($urandom_range(0, 755000000)) - 377500000, LAT_LO, LAT_HI));
  endfunction

  function automatic logic [CFG_W-1:0] rand_lon();
    return CFG_W'(clamp(longint'($urandom_range(0, 1510000000)) - 755000000, LON_LO, LON_HI));
  endfunction

  initial begin
    int len;
    @(posedge rst_n);
    @(posedge clk);

    // single point, mirrored extremes through the origin, zero length, tie, far end
    send_point(make_point(1234, -5678, 77, 1));
    send_point(make_point(LAT_LO, LON_LO, 0, 0));
    send_point(make_point(LAT_HI, LON_HI, 24'hFFFFFF, 0));
    send_point(make_point(LAT_HI, LON_HI, 5, 1));
    send_point(make_point(0, 1000, 9, 0));
    send_point(make_point(1000, 1000, 1, 0));
    send_point(make_point(0, 1000, 2, 0));
    send_point(make_point(0, 1000, 3, 0));
    send_point(make_point(300000, 300000, 4, 0));
    send_point(make_point(600000, 100000, 6, 1));
    send_point(make_point(-7, 3, 8, 0));
    send_point(make_point(-7, 3, 10, 1));
    drain();

    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      quiet_phase = (phase % 6 == 1);
      write_reg(CFG_SPARE, CFG_W'($urandom));
      case (phase % 5)
        0: begin
          write_reg(CFG_QUERY_LAT, rand_lat());
          write_reg(CFG_QUERY_LON, rand_lon());
          write_reg(CFG_LIMIT, CFG_W'($urandom_range(0, 2000000)));
        end
        1: begin
          write_reg(CFG_QUERY_LAT, CFG_W'(LAT_HI));
          write_reg(CFG_QUERY_LON, CFG_W'(LON_HI));
          write_reg(CFG_LIMIT, CFG_W'(DIST_MAX));
        end
        2: begin
          write_reg(CFG_QUERY_LAT, CFG_W'(LAT_LO));
          write_reg(CFG_QUERY_LON, CFG_W'(LON_LO));
          write_reg(CFG_LIMIT, '0);
        end
        3: begin
          write_reg(CFG_QUERY_LAT, rand_lat());
          write_reg(CFG_QUERY_LON, rand_lon());
          write_reg(CFG_LIMIT, CFG_W'(1));
        end
        default: begin
          write_reg(CFG_QUERY_LAT, rand_lat());
          write_reg(CFG_QUERY_LON, rand_lon());
          write_reg(CFG_LIMIT, CFG_W'($urandom_range(0, 67108863)));
        end
      endcase
      if (phase == 2) hold_armed = 1;
      for (int n = 0; n < 200; n += len) begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
          send_point(random_point(k == len - 1));
        if (phase == 4 && n < 20) drain();
      end
      drain();
    end

    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

@@ nearest_track_segment_search_unit.f @@
+incdir+sv
sv/ntss_pkg.sv
sv/ntss_in_if.sv
sv/ntss_out_if.sv
sv/ntss_mac.sv
sv/ntss_iter.sv
sv/nearest_track_segment_search_unit.sv
tb/nearest_track_segment_search_unit_test.sv
